[sv/bmpck_pkg.sv]
// Shared types and constants for the 24-bit bitmap blitter with color key.
// No dependencies; imported by the top level and its port checker.
`timescale 1ns / 1ps

package bmpck_pkg;

  localparam int CFG_DATA_BITS  = 11;
  localparam int CFG_INDEX_BITS = 3;
  localparam int ORIGIN_BITS    = 10;
  localparam int DIM_BITS       = 11;
  localparam int COUNT_BITS     = 11;

  localparam logic [CFG_INDEX_BITS-1:0] REG_ORIGIN_X     = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ORIGIN_Y     = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KEY_ENABLE   = 3'd4;

  localparam logic [1:0] PHASE_BLUE  = 2'd0;
  localparam logic [1:0] PHASE_GREEN = 2'd1;
  localparam logic [1:0] PHASE_RED   = 2'd2;

  localparam logic [7:0] KEY_RED   = 8'hFF;
  localparam logic [7:0] KEY_GREEN = 8'h00;
  localparam logic [7:0] KEY_BLUE  = 8'h00;

  localparam int BYTES_PER_PIXEL = 3;

  typedef logic [7:0] color_t;

endpackage

[sv/bmp24_blit_colour_key_top.sv]
// Top level of the 24-bit bitmap blitter with color key.
// Depends on bmpck_pkg.
`timescale 1ns / 1ps

// Takes one bitmap byte per cycle (blue, green, red per pixel, row padding
// included) and issues one frame-buffer write request per complete pixel.
// A byte is accepted every cycle while the result register is empty or is
// being drained, so the stream runs at one byte a cycle; a pixel's request
// is registered as its red byte is accepted. The pitch multiply and address
// add sit in front of the result register. Rows are drawn bottom-up; the
// user must write configuration only while the block is idle; unenforced.
module bmp24_blit_colour_key_top import bmpck_pkg::*; #(
  parameter int LINE_PITCH = 2400,
  parameter int ADDR_BITS  = 23
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      config_write,
  input  logic [CFG_INDEX_BITS-1:0] config_index,
  input  logic [CFG_DATA_BITS-1:0]  config_data,
  input  logic                      source_valid,
  output logic                      source_ready,
  input  logic [7:0]                source_byte,
  output logic                      result_valid,
  input  logic                      result_ready,
  output logic [ADDR_BITS-1:0]      pixel_address,
  output logic [7:0]                red,
  output logic [7:0]                green,
  output logic [7:0]                blue,
  output logic                      write_enable,
  output logic                      last_pixel
);

  localparam logic [ADDR_BITS-1:0] PITCH = ADDR_BITS'(LINE_PITCH);

  logic [ORIGIN_BITS-1:0] origin_x;
  logic [ORIGIN_BITS-1:0] origin_y;
  logic [DIM_BITS-1:0]    image_width;
  logic [DIM_BITS-1:0]    image_height;
  logic                   key_enable;

  logic [1:0]            byte_phase;
  color_t                held_blue;
  color_t                held_green;
  logic [COUNT_BITS-1:0] column_count;
  logic [COUNT_BITS-1:0] row_count;
  logic [1:0]            pad_count;

  logic                  accept;
  logic                  pixel_done;
  logic                  row_end;
  logic                  img_end;
  logic                  keyed;
  logic [ADDR_BITS-1:0]  dest_row;
  logic [ADDR_BITS-1:0]  dest_col;
  logic [ADDR_BITS-1:0]  address_next;

  assign source_ready = !result_valid || result_ready;
  assign accept       = source_valid && source_ready;
  assign pixel_done   = accept && (pad_count == 2'd0) && (byte_phase == PHASE_RED);

  assign row_end = ({1'b0, column_count} + 12'd1) >= {1'b0, image_width};
  assign img_end = row_end && (({1'b0, row_count} + 12'd1) >= {1'b0, image_height});
  assign keyed   = key_enable && (source_byte == KEY_RED) && (held_green == KEY_GREEN)
                   && (held_blue == KEY_BLUE);

  assign dest_row = ADDR_BITS'(origin_y) + ADDR_BITS'(image_height) - ADDR_BITS'(1)
                    - ADDR_BITS'(row_count);
  assign dest_col = ADDR_BITS'(origin_x) + ADDR_BITS'(column_count);
  assign address_next = (dest_row * PITCH) + (dest_col * ADDR_BITS'(BYTES_PER_PIXEL));

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x     <= '0;
      origin_y     <= '0;
      image_width  <= DIM_BITS'(1);
      image_height <= DIM_BITS'(1);
      key_enable   <= 1'b0;
    end else if (config_write) begin
      unique case (config_index)
        REG_ORIGIN_X:     origin_x     <= config_data[ORIGIN_BITS-1:0];
        REG_ORIGIN_Y:     origin_y     <= config_data[ORIGIN_BITS-1:0];
        REG_IMAGE_WIDTH:  image_width  <= config_data[DIM_BITS-1:0];
        REG_IMAGE_HEIGHT: image_height <= config_data[DIM_BITS-1:0];
        REG_KEY_ENABLE:   key_enable   <= config_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase   <= PHASE_BLUE;
      held_blue    <= '0;
      held_green   <= '0;
      column_count <= '0;
      row_count    <= '0;
      pad_count    <= '0;
    end else if (accept) begin
      if (pad_count != 2'd0) begin
        pad_count <= pad_count - 2'd1;
      end else if (byte_phase == PHASE_BLUE) begin
        held_blue  <= source_byte;
        byte_phase <= PHASE_GREEN;
      end else if (byte_phase == PHASE_GREEN) begin
        held_green <= source_byte;
        byte_phase <= PHASE_RED;
      end else begin
        byte_phase <= PHASE_BLUE;
        if (row_end) begin
          column_count <= '0;
          pad_count    <= image_width[1:0];
          row_count    <= img_end ? '0 : row_count + COUNT_BITS'(1);
        end else begin
          column_count <= column_count + COUNT_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pixel_done) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_done) begin
      pixel_address <= address_next;
      red           <= source_byte;
      green         <= held_green;
      blue          <= held_blue;
      write_enable  <= !keyed;
      last_pixel    <= img_end;
    end
  end

endmodule

[sv/bmpck_checker.sv]
// Port-level checker for the bitmap blitter, bound to its top level.
// Depends on bmpck_pkg and bmp24_blit_colour_key_top.
`timescale 1ns / 1ps

module bmpck_checker import bmpck_pkg::*; #(
  parameter int ADDR_BITS = 23
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      source_ready,
  input logic                      result_valid,
  input logic                      result_ready,
  input logic [ADDR_BITS-1:0]      pixel_address,
  input logic [7:0]                red,
  input logic [7:0]                green,
  input logic [7:0]                blue,
  input logic                      write_enable,
  input logic                      last_pixel
);

  // hold a stalled request
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(pixel_address)
      && $stable(red) && $stable(green) && $stable(blue)
      && $stable(write_enable) && $stable(last_pixel))
    else $error("stalled request changed");

  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("request pending after reset");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> source_ready)
    else $error("input stalled with empty output");

  a_key: assert property (@(posedge clk) disable iff (rst)
    result_valid && !write_enable |-> red == KEY_RED && green == KEY_GREEN
      && blue == KEY_BLUE)
    else $error("write dropped for a non-key color");

endmodule

bind bmp24_blit_colour_key_top bmpck_checker #(.ADDR_BITS(ADDR_BITS)) u_checker (.*);

[verif/tb.sv]
// Self-checking testbench for the 24-bit bitmap blitter with color key.
// Streams bitmap bytes under random idling and back-pressure and checks every
// frame-buffer write request against an in-bench model; depends on bmpck_pkg.
`timescale 1ns / 1ps

module tb;
  import bmpck_pkg::*;

  localparam int LINE_PITCH     = 2400;
  localparam int ADDR_BITS      = 23;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int MAX_PRINTED    = 40;

  typedef struct packed {
    logic [ADDR_BITS-1:0] addr;
    color_t               red;
    color_t               green;
    color_t               blue;
    logic                 write_en;
    logic                 is_last;
  } pixel_request_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      config_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] config_index = '0;
  logic [CFG_DATA_BITS-1:0]  config_data = '0;
  logic                      source_valid = 1'b0;
  logic                      source_ready;
  logic [7:0]                source_byte = '0;
  logic                      result_valid;
  logic                      result_ready = 1'b0;
  logic [ADDR_BITS-1:0]      pixel_address;
  logic [7:0]                red;
  logic [7:0]                green;
  logic [7:0]                blue;
  logic                      write_enable;
  logic                      last_pixel;

  // blitter model: configuration copy and stream state
  logic [ORIGIN_BITS-1:0] cfg_ox = '0;
  logic [ORIGIN_BITS-1:0] cfg_oy = '0;
  logic [DIM_BITS-1:0]    cfg_w = 11'd1;
  logic [DIM_BITS-1:0]    cfg_h = 11'd1;
  logic                   cfg_key = 1'b0;
  logic [1:0]             phase_q = PHASE_BLUE;
  color_t                 held_b = '0;
  color_t                 held_g = '0;
  logic [COUNT_BITS-1:0]  col_q = '0;
  logic [COUNT_BITS-1:0]  row_q = '0;
  logic [1:0]             pad_left = '0;

  pixel_request_t pending_requests[$];
  int             error_count = 0;
  int             bytes_sent = 0;
  int             tx_idle_pct = 0;
  int             rx_idle_pct = 0;
  logic           rx_hold = 1'b0;

  bmp24_blit_colour_key_top #(
    .LINE_PITCH(LINE_PITCH),
    .ADDR_BITS (ADDR_BITS)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .config_write (config_write),
    .config_index (config_index),
    .config_data  (config_data),
    .source_valid (source_valid),
    .source_ready (source_ready),
    .source_byte  (source_byte),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .pixel_address(pixel_address),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .write_enable (write_enable),
    .last_pixel   (last_pixel)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTED) $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  task automatic model_source_byte(input color_t value);
    logic [63:0]    dest_row;
    logic [63:0]    dest_col;
    logic [63:0]    addr;
    logic           row_end;
    logic           img_end;
    pixel_request_t req;
    if (pad_left != 0) begin
      pad_left = pad_left - 2'd1;
    end else if (phase_q == PHASE_BLUE) begin
      held_b = value;
      phase_q = PHASE_GREEN;
    end else if (phase_q == PHASE_GREEN) begin
      held_g = value;
      phase_q = PHASE_RED;
    end else begin
      dest_row = 64'(cfg_oy) + 64'(cfg_h) - 64'd1 - 64'(row_q);
      dest_col = 64'(cfg_ox) + 64'(col_q);
      addr = 64'(LINE_PITCH) * dest_row + 64'(BYTES_PER_PIXEL) * dest_col;
      row_end = (32'(col_q) + 32'd1) >= 32'(cfg_w);
      img_end = row_end && ((32'(row_q) + 32'd1) >= 32'(cfg_h));
      req.addr = addr[ADDR_BITS-1:0];
      req.red = value;
      req.green = held_g;
      req.blue = held_b;
      req.write_en = !(cfg_key && value == KEY_RED && held_g == KEY_GREEN &&
                       held_b == KEY_BLUE);
      req.is_last = img_end;
      pending_requests.push_back(req);
      phase_q = PHASE_BLUE;
      if (row_end) begin
        col_q = '0;
        pad_left = cfg_w[1:0];
        row_q = img_end ? '0 : row_q + COUNT_BITS'(1);
      end else begin
        col_q = col_q + COUNT_BITS'(1);
      end
    end
  endtask

  always @(posedge clk) begin : check_requests
    pixel_request_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_requests.size() == 0) begin
        report_mismatch("write request with none pending");
      end else begin
        want = pending_requests.pop_front();
        if (pixel_address !== want.addr)
          report_mismatch($sformatf("pixel_address %0h, want %0h", pixel_address, want.addr));
        if (red !== want.red)
          report_mismatch($sformatf("red %0h, want %0h", red, want.red));
        if (green !== want.green)
          report_mismatch($sformatf("green %0h, want %0h", green, want.green));
        if (blue !== want.blue)
          report_mismatch($sformatf("blue %0h, want %0h", blue, want.blue));
        if (write_enable !== want.write_en)
          report_mismatch($sformatf("write_enable %b, want %b", write_enable, want.write_en));
        if (last_pixel !== want.is_last)
          report_mismatch($sformatf("last_pixel %b, want %b", last_pixel, want.is_last));
      end
    end
  end

  always @(posedge clk) begin
    if (rx_hold) begin
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_byte(input color_t value);
    while ($urandom_range(99) < tx_idle_pct) begin
      source_valid <= 1'b0;
      @(posedge clk);
    end
    source_valid <= 1'b1;
    source_byte <= value;
    @(posedge clk);
    while (!source_ready) @(posedge clk);
    model_source_byte(value);
    bytes_sent++;
  endtask

  // flush pending row padding, then send blue, green, red
  task automatic send_pixel(input color_t r, input color_t g, input color_t b);
    while (pad_left != 0) send_byte(color_t'($urandom));
    send_byte(b);
    send_byte(g);
    send_byte(r);
  endtask

  function automatic logic [23:0] pick_pixel();
    int sel;
    sel = $urandom_range(99);
    if (sel < 15) return {KEY_RED, KEY_GREEN, KEY_BLUE};
    if (sel < 25) return {KEY_RED, KEY_GREEN, KEY_BLUE} ^ (24'd1 << $urandom_range(23));
    return 24'($urandom);
  endfunction

  task automatic stream_pixels(input int count);
    logic [23:0] px;
    repeat (count) begin
      px = pick_pixel();
      send_pixel(px[23:16], px[15:8], px[7:0]);
    end
  endtask

  task automatic settle();
    source_valid <= 1'b0;
    while (pending_requests.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_BITS-1:0] index,
                                input logic [CFG_DATA_BITS-1:0] data);
    config_write <= 1'b1;
    config_index <= index;
    config_data <= data;
    @(posedge clk);
    case (index)
      REG_ORIGIN_X:     cfg_ox = data[ORIGIN_BITS-1:0];
      REG_ORIGIN_Y:     cfg_oy = data[ORIGIN_BITS-1:0];
      REG_IMAGE_WIDTH:  cfg_w = data[DIM_BITS-1:0];
      REG_IMAGE_HEIGHT: cfg_h = data[DIM_BITS-1:0];
      REG_KEY_ENABLE:   cfg_key = data[0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input int ox, input int oy, input int w, input int h,
                              input int key);
    logic [CFG_DATA_BITS-1:0] key_word;
    settle();
    key_word = CFG_DATA_BITS'($urandom);
    key_word[0] = key[0];
    write_register(REG_ORIGIN_X, CFG_DATA_BITS'(ox));
    write_register(REG_ORIGIN_Y, CFG_DATA_BITS'(oy));
    write_register(REG_IMAGE_WIDTH, CFG_DATA_BITS'(w));
    write_register(REG_IMAGE_HEIGHT, CFG_DATA_BITS'(h));
    write_register(REG_KEY_ENABLE, key_word);
    // unused index, must be ignored
    write_register(REG_KEY_ENABLE + CFG_INDEX_BITS'($urandom_range(1, 3)),
                   CFG_DATA_BITS'($urandom));
    config_write <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_pixel(KEY_RED, KEY_GREEN, KEY_BLUE);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
  endtask

  task automatic test_color_key();
    apply_config(5, 7, 2, 1, 1);
    send_pixel(KEY_RED, KEY_GREEN, KEY_BLUE);
    send_pixel(KEY_RED, KEY_GREEN, 8'h01);
  endtask

  task automatic test_address_extremes();
    apply_config(2047, 1023, 1, 1, 0);
    send_pixel(8'h00, 8'h00, 8'h00);
    apply_config(0, 0, 0, 0, 1);
    send_pixel(8'h5A, 8'hA5, 8'h3C);
    apply_config(1023, 1023, 2047, 2047, 1);
    send_pixel(KEY_RED, KEY_GREEN, KEY_BLUE);
  endtask

  task automatic test_backpressure();
    apply_config(100, 200, 4, 3, 1);
    fork
      begin
        rx_hold <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    stream_pixels(24);
  endtask

  task automatic test_large_frames();
    apply_config(0, 0, 1024, 1, 1);
    stream_pixels(40);
    apply_config(1023, 1023, 1, 1024, 0);
    stream_pixels(40);
  endtask

  task automatic test_random_images(input int budget);
    int first;
    int sel;
    int w;
    int h;
    int pixels;
    first = bytes_sent;
    while (bytes_sent - first < budget) begin
      if ($urandom_range(99) < 70) begin
        sel = $urandom_range(99);
        w = (sel < 75) ? $urandom_range(1, 8) : (sel < 87) ? $urandom_range(9, 48) :
            (sel < 93) ? 0 : $urandom_range(49, 2047);
        sel = $urandom_range(99);
        h = (sel < 80) ? $urandom_range(1, 4) : (sel < 88) ? 0 :
            (sel < 94) ? $urandom_range(5, 32) : $urandom_range(33, 2047);
        apply_config($urandom_range(2047), $urandom_range(2047), w, h, $urandom_range(1));
      end
      pixels = (cfg_w == 0 ? 1 : int'(cfg_w)) * (cfg_h == 0 ? 1 : int'(cfg_h));
      sel = $urandom_range(99);
      if (sel < 80 && pixels <= 96) begin
        stream_pixels(pixels);
      end else if (sel < 92) begin
        stream_pixels($urandom_range(1, 40));
      end else begin
        repeat ($urandom_range(1, 8)) send_byte(color_t'($urandom));
      end
    end
  endtask

  initial begin
    tx_idle_pct = 36;
    rx_idle_pct <= 76;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_color_key();
    test_address_extremes();
    test_backpressure();
    test_random_images(280);
    settle();
    tx_idle_pct = 76;
    rx_idle_pct <= 36;
    test_random_images(280);
    settle();
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    test_large_frames();
    test_random_images(280);
    settle();
    if (pending_requests.size() != 0)
      report_mismatch($sformatf("%0d write requests never issued", pending_requests.size()));
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
